FILE: rtl/core/srwf_pkg.sv
// Shared types and constants for the secure register write filter.
// Depends on nothing; used by secure_register_write_filter, srwf_checker and testbench.
`default_nettype none

package srwf_pkg;

  // Default sizing
  localparam int NUM_BANKS_DEF        = 7;
  localparam int PIN_WINDOW_BYTES_DEF = 64;
  localparam int MUX_WINDOW_BYTES_DEF = 240;

  // Fixed protocol constants
  localparam int        MUX_BANK_STRIDE = 12;
  localparam logic [1:0] WORD_SIZE_CODE = 2'd2;

  // Request commands
  typedef enum logic [1:0] {
    CMD_ADD_WINDOW = 2'd0,
    CMD_SET_MASK   = 2'd1,
    CMD_PIN_ACCESS = 2'd2,
    CMD_MUX_ACCESS = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_HANDLED   = 2'd0,
    ST_PASS      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // One request
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] address;
    logic [2:0]  bank;
    logic [31:0] protect_mask;
    logic [1:0]  size_code;
    logic        is_write;
    logic [31:0] write_data;
    logic [31:0] current_value;
  } req_t;

  // One result
  typedef struct packed {
    logic [1:0]  status;
    logic        do_write;
    logic [31:0] merged_data;
    logic [31:0] read_data;
    logic        protected_change;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/secure_register_write_filter.sv
// Bus firewall guarding secure bits of pin registers: top level.
// Depends on srwf_pkg for request/result types, commands and status codes.
//
// Every request is accepted at its start edge; done is registered at the same
// edge as the result, so the result is valid while done is high. A new request
// may start in every cycle: busy is always low. A request passes three register
// stages: window table match, protect-mask lookup with merge, and the result
// register. Each result is shown for one cycle only, so the receiver must take
// it when done is high.
// Setup requests take effect for every request started after them.
// Write cfg_data with cfg_we only while no request is in flight.
`default_nettype none

module secure_register_write_filter #(
  parameter int NUM_BANKS        = srwf_pkg::NUM_BANKS_DEF,
  parameter int PIN_WINDOW_BYTES = srwf_pkg::PIN_WINDOW_BYTES_DEF,
  parameter int MUX_WINDOW_BYTES = srwf_pkg::MUX_WINDOW_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire srwf_pkg::req_t   req,
  output logic                  done,
  output srwf_pkg::result_t     result,
  input  wire logic             cfg_we,
  input  wire logic [31:0]      cfg_data
);

  localparam int IDXW  = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int CNTW  = $clog2(NUM_BANKS + 1);
  localparam int OFFW  = $clog2(MUX_WINDOW_BYTES);
  localparam logic [CNTW-1:0] COUNT_MAX = CNTW'(NUM_BANKS);
  localparam logic [32:0] PIN_SPAN = 33'(PIN_WINDOW_BYTES);
  localparam logic [32:0] MUX_SPAN = 33'(MUX_WINDOW_BYTES);
  localparam logic [31:0] MUX_LIMIT = 32'(srwf_pkg::MUX_BANK_STRIDE * NUM_BANKS);

  // Configuration
  logic [31:0] pinmux_base;

  // Window table and masks
  logic [31:0]     window_base [NUM_BANKS];
  logic [2:0]      window_bank [NUM_BANKS];
  logic [CNTW-1:0] window_count;
  logic [31:0]     bank_mask   [NUM_BANKS];

  // Stage 1 registers
  logic           s1_valid;
  srwf_pkg::req_t s1_req;

  // Stage 2 registers
  logic            s2_valid;
  srwf_pkg::req_t  s2_req;
  logic            s2_full;
  logic            s2_found;
  logic [2:0]      s2_win_bank;
  logic            s2_mux_hit;
  logic [OFFW-1:0] s2_mux_off;

  // Stage 1 combinational
  logic            s1_full;
  logic            s1_found;
  logic [2:0]      s1_win_bank;
  logic            s1_mux_hit;
  logic [OFFW-1:0] s1_mux_off;
  logic [31:0]     s1_off_full;

  // Stage 2 combinational
  logic [31:0]       pin_mask;
  logic [IDXW-1:0]   mux_idx;
  logic              mux_in_range;
  logic [31:0]       mux_mask;
  logic              guard;
  logic [31:0]       guard_mask;
  srwf_pkg::result_t result_next;

  assign busy = 1'b0;

  // Hold the pin-mux base
  always_ff @(posedge clk) begin
    if (rst) begin
      pinmux_base <= '0;
    end else if (cfg_we) begin
      pinmux_base <= cfg_data;
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start & ~busy;
      s2_valid <= s1_valid;
      done     <= s2_valid;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    s1_req <= req;
  end

  // Match against the window table, first registered window wins
  always_comb begin
    s1_full     = (window_count >= COUNT_MAX);
    s1_found    = 1'b0;
    s1_win_bank = '0;
    for (int i = NUM_BANKS - 1; i >= 0; i--) begin
      if ((CNTW'(i) < window_count) &&
          (s1_req.address >= window_base[i]) &&
          ({1'b0, s1_req.address} < ({1'b0, window_base[i]} + PIN_SPAN))) begin
        s1_found    = 1'b1;
        s1_win_bank = window_bank[i];
      end
    end
    s1_mux_hit  = (s1_req.address >= pinmux_base) &&
                  ({1'b0, s1_req.address} < ({1'b0, pinmux_base} + MUX_SPAN));
    s1_off_full = s1_req.address - pinmux_base;
    s1_mux_off  = s1_off_full[OFFW-1:0];
  end

  // Append a window
  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
    end else if (s1_valid && (s1_req.command == srwf_pkg::CMD_ADD_WINDOW) && !s1_full) begin
      window_count <= window_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_BANKS; i++) begin
      if (s1_valid && (s1_req.command == srwf_pkg::CMD_ADD_WINDOW) && !s1_full &&
          (window_count == CNTW'(i))) begin
        window_base[i] <= s1_req.address;
        window_bank[i] <= s1_req.bank;
      end
    end
  end

  // Stage 2 payload
  always_ff @(posedge clk) begin
    s2_req      <= s1_req;
    s2_full     <= s1_full;
    s2_found    <= s1_found;
    s2_win_bank <= s1_win_bank;
    s2_mux_hit  <= s1_mux_hit;
    s2_mux_off  <= s1_mux_off;
  end

  // Update a protect mask
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BANKS; i++) begin
        bank_mask[i] <= '0;
      end
    end else if (s2_valid && (s2_req.command == srwf_pkg::CMD_SET_MASK)) begin
      for (int i = 0; i < NUM_BANKS; i++) begin
        if (32'(s2_req.bank) == 32'(i)) begin
          bank_mask[i] <= s2_req.protect_mask;
        end
      end
    end
  end

  // Look up masks: window bank and pin-mux bank (offset over the stride)
  always_comb begin
    pin_mask     = '0;
    mux_mask     = '0;
    mux_idx      = '0;
    mux_in_range = ({{(32-OFFW){1'b0}}, s2_mux_off} < MUX_LIMIT);
    for (int k = 1; k < NUM_BANKS; k++) begin
      if ({{(32-OFFW){1'b0}}, s2_mux_off} >= 32'(srwf_pkg::MUX_BANK_STRIDE * k)) begin
        mux_idx = IDXW'(k);
      end
    end
    for (int i = 0; i < NUM_BANKS; i++) begin
      if (32'(s2_win_bank) == 32'(i)) begin
        pin_mask = bank_mask[i];
      end
      if (32'(mux_idx) == 32'(i)) begin
        mux_mask = bank_mask[i];
      end
    end
  end

  // Decide status and merge the access
  always_comb begin
    result_next = '0;
    guard       = 1'b0;
    guard_mask  = pin_mask;
    case (srwf_pkg::cmd_t'(s2_req.command))
      srwf_pkg::CMD_ADD_WINDOW: begin
        result_next.status = s2_full ? srwf_pkg::ST_FULL : srwf_pkg::ST_HANDLED;
      end
      srwf_pkg::CMD_SET_MASK: begin
        result_next.status = srwf_pkg::ST_HANDLED;
      end
      srwf_pkg::CMD_PIN_ACCESS: begin
        if (s2_found) begin
          result_next.status = srwf_pkg::ST_HANDLED;
          guard              = 1'b1;
        end else begin
          result_next.status = srwf_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        guard_mask = mux_mask;
        if (!s2_mux_hit) begin
          result_next.status = srwf_pkg::ST_NOT_FOUND;
        end else if (!mux_in_range) begin
          result_next.status = srwf_pkg::ST_HANDLED;
        end else if (mux_mask == '0) begin
          result_next.status = srwf_pkg::ST_PASS;
        end else begin
          result_next.status = srwf_pkg::ST_HANDLED;
          guard              = 1'b1;
        end
      end
    endcase
    if (guard && (s2_req.size_code == srwf_pkg::WORD_SIZE_CODE)) begin
      if (s2_req.is_write) begin
        result_next.do_write         = 1'b1;
        result_next.merged_data      = (s2_req.write_data & ~guard_mask) |
                                       (s2_req.current_value & guard_mask);
        result_next.protected_change = |((s2_req.write_data ^ s2_req.current_value) &
                                         guard_mask);
      end else begin
        result_next.read_data = s2_req.current_value;
      end
    end
  end

  // Hold the result for its strobe cycle
  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

`default_nettype wire

FILE: test/srwf_checker.sv
// Response checker for the secure register write filter: watches the request,
// response and configuration ports, predicts each response and compares it.
// Depends on srwf_pkg for the request/response types, commands and status codes.
`timescale 1ns / 100ps

module srwf_checker #(
  parameter int NUM_BANKS        = srwf_pkg::NUM_BANKS_DEF,
  parameter int PIN_WINDOW_BYTES = srwf_pkg::PIN_WINDOW_BYTES_DEF,
  parameter int MUX_WINDOW_BYTES = srwf_pkg::MUX_WINDOW_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  srwf_pkg::req_t    req,
  input  logic              done,
  input  srwf_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data,
  output int                errors,
  output int                outstanding
);

  // Mirror of the firewall state
  logic [31:0] mux_base;
  logic [31:0] win_base [NUM_BANKS];
  logic [2:0]  win_bank [NUM_BANKS];
  int          win_count;
  logic [31:0] bank_mask [NUM_BANKS];

  srwf_pkg::result_t awaited_responses [$];
  srwf_pkg::result_t want;
  srwf_pkg::result_t got;

  // Protect mask of a bank; banks past the table have none
  function automatic logic [31:0] mask_of_bank(input logic [2:0] bank);
    mask_of_bank = (int'(bank) < NUM_BANKS) ? bank_mask[bank] : 32'h0;
  endfunction

  // Word access merged against a protect mask
  function automatic srwf_pkg::result_t guard_word(input logic [31:0] mask,
                                                   input srwf_pkg::req_t r);
    srwf_pkg::result_t res;
    res = '0;
    res.status = srwf_pkg::ST_HANDLED;
    if (r.size_code == srwf_pkg::WORD_SIZE_CODE) begin
      if (r.is_write) begin
        res.do_write         = 1'b1;
        res.merged_data      = (r.write_data & ~mask) | (r.current_value & mask);
        res.protected_change = |((r.write_data ^ r.current_value) & mask);
      end else begin
        res.read_data = r.current_value;
      end
    end
    return res;
  endfunction

  // Filter one request against the mirrored state, updating it for setup commands
  task automatic apply_filter(input srwf_pkg::req_t r, output srwf_pkg::result_t res);
    logic [32:0] lo;
    logic [32:0] hi;
    logic [31:0] offset;
    int          mux_bank;
    bit          hit;
    res = '0;
    res.status = srwf_pkg::ST_HANDLED;
    hit = 1'b0;
    case (srwf_pkg::cmd_t'(r.command))
      srwf_pkg::CMD_ADD_WINDOW: begin
        if (win_count >= NUM_BANKS) begin
          res.status = srwf_pkg::ST_FULL;
        end else begin
          win_base[win_count] = r.address;
          win_bank[win_count] = r.bank;
          win_count++;
        end
      end
      srwf_pkg::CMD_SET_MASK: begin
        if (int'(r.bank) < NUM_BANKS) bank_mask[r.bank] = r.protect_mask;
      end
      srwf_pkg::CMD_PIN_ACCESS: begin
        // First registered window that covers the address wins
        for (int i = 0; i < win_count; i++) begin
          lo = {1'b0, win_base[i]};
          hi = lo + 33'(PIN_WINDOW_BYTES);
          if (!hit && {1'b0, r.address} >= lo && {1'b0, r.address} < hi) begin
            res = guard_word(mask_of_bank(win_bank[i]), r);
            hit = 1'b1;
          end
        end
        if (!hit) res.status = srwf_pkg::ST_NOT_FOUND;
      end
      default: begin
        lo = {1'b0, mux_base};
        hi = lo + 33'(MUX_WINDOW_BYTES);
        if ({1'b0, r.address} >= lo && {1'b0, r.address} < hi) begin
          offset   = r.address - mux_base;
          mux_bank = int'(offset / srwf_pkg::MUX_BANK_STRIDE);
          if (mux_bank < NUM_BANKS) begin
            if (bank_mask[mux_bank] == 32'h0) res.status = srwf_pkg::ST_PASS;
            else res = guard_word(bank_mask[mux_bank], r);
          end
        end else begin
          res.status = srwf_pkg::ST_NOT_FOUND;
        end
      end
    endcase
  endtask

  // Compare responses, track configuration, predict accepted requests
  always @(posedge clk) begin
    if (rst) begin
      mux_base  = 32'h0;
      win_count = 0;
      for (int i = 0; i < NUM_BANKS; i++) begin
        win_base[i]  = 32'h0;
        win_bank[i]  = 3'h0;
        bank_mask[i] = 32'h0;
      end
      awaited_responses.delete();
      errors = 0;
      outstanding <= 0;
    end else begin
      if (done) begin
        got = result;
        if (awaited_responses.size() == 0) begin
          if (errors < 10) $display("response with no request waiting: %h", got);
          errors++;
        end else begin
          want = awaited_responses.pop_front();
          if (got.status !== want.status || got.do_write !== want.do_write ||
              got.merged_data !== want.merged_data || got.read_data !== want.read_data ||
              got.protected_change !== want.protected_change) begin
            if (errors < 10) begin
              $display("mismatch: expected status=%0d wr=%0b merged=%h read=%h prot=%0b",
                       want.status, want.do_write, want.merged_data, want.read_data,
                       want.protected_change);
              $display("          actual   status=%0d wr=%0b merged=%h read=%h prot=%0b",
                       got.status, got.do_write, got.merged_data, got.read_data,
                       got.protected_change);
            end
            errors++;
          end
        end
      end
      if (cfg_we) mux_base = cfg_data;
      if (start && !busy) begin
        apply_filter(req, want);
        awaited_responses.push_back(want);
      end
      outstanding <= awaited_responses.size();
    end
  end

endmodule

FILE: test/testbench.sv
// Top of the secure register write filter test: drives directed and random requests
// and pin-mux base settings; srwf_checker predicts and compares the responses.
// Depends on srwf_pkg, secure_register_write_filter and srwf_checker.
`timescale 1ns / 100ps

module testbench;

  localparam int ITEMS_PER_PHASE = 92;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  srwf_pkg::req_t    req;
  logic              done;
  srwf_pkg::result_t result;
  logic              cfg_we;
  logic [31:0]       cfg_data;
  int                errors;
  int                outstanding;

  logic [31:0] pin_base [7];
  logic [31:0] mux_base;
  logic [31:0] phase_base [6];
  int          burst_left;

  secure_register_write_filter u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  srwf_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic srwf_pkg::req_t mk_req(input srwf_pkg::cmd_t cmd,
                                            input logic [31:0] addr,
                                            input logic [2:0] bank, input logic [31:0] mask,
                                            input logic [1:0] size, input logic wr,
                                            input logic [31:0] wdata, input logic [31:0] cur);
    srwf_pkg::req_t r;
    r.command       = cmd;
    r.address       = addr;
    r.bank          = bank;
    r.protect_mask  = mask;
    r.size_code     = size;
    r.is_write      = wr;
    r.write_data    = wdata;
    r.current_value = cur;
    return r;
  endfunction

  // Random request; accesses mostly aimed at the registered windows and the pin-mux window
  function automatic srwf_pkg::req_t rand_req();
    srwf_pkg::req_t r;
    int unsigned    pick;
    logic [31:0]    mask;
    pick = $urandom_range(0, 99);
    r.address       = $urandom;
    r.bank          = 3'($urandom_range(0, 7));
    r.size_code     = ($urandom_range(0, 3) != 0) ? srwf_pkg::WORD_SIZE_CODE :
                                                    2'($urandom_range(0, 3));
    r.is_write      = 1'($urandom);
    r.current_value = $urandom;
    case ($urandom_range(0, 2))
      0:       r.write_data = $urandom;
      1:       r.write_data = r.current_value;
      default: r.write_data = r.current_value ^ ($urandom & 32'h0000_00FF);
    endcase
    case ($urandom_range(0, 3))
      0:       mask = 32'h0;
      1:       mask = 32'hFFFF_FFFF;
      2:       mask = 32'h1 << $urandom_range(0, 31);
      default: mask = $urandom;
    endcase
    r.protect_mask = mask;
    if (pick < 3) begin
      r.command = srwf_pkg::CMD_ADD_WINDOW;
    end else if (pick < 15) begin
      r.command = srwf_pkg::CMD_SET_MASK;
    end else if (pick < 57) begin
      r.command = srwf_pkg::CMD_PIN_ACCESS;
      if ($urandom_range(0, 4) != 0)
        r.address = pin_base[$urandom_range(0, 6)] + $urandom_range(0, 79) - 8;
    end else begin
      r.command = srwf_pkg::CMD_MUX_ACCESS;
      if ($urandom_range(0, 6) != 0)
        r.address = mux_base + $urandom_range(0, 255) - 8;
    end
    return r;
  endfunction

  // Present one request and hold it until accepted
  task automatic send(input srwf_pkg::req_t r);
    req   <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // End the burst with a gap when it runs out
  task automatic pace();
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // Drain the pipeline, then write the pin-mux base
  task automatic drain_and_set_base(input logic [31:0] base);
    if (start) start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= base;
    mux_base  = base;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    req        = '0;
    cfg_we     = 1'b0;
    cfg_data   = 32'h0;
    mux_base   = 32'h0;
    burst_left = $urandom_range(1, 40);
    pin_base   = '{32'h0000_0000, 32'h4000_1000, 32'h4000_1020, 32'hFFFF_FFF0,
                  32'h8000_0000, $urandom & 32'hFFFF_FFFC, 32'h4000_2000};
    phase_base = '{32'h4000_3000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FF40,
                   $urandom & 32'hFFFF_FFFC, $urandom};
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    drain_and_set_base(32'h4000_3000);

    // Fill the window table, overlapping and top-of-space windows included
    send(mk_req(srwf_pkg::CMD_ADD_WINDOW, pin_base[0], 3'd0, 32'h0, 2'd0, 1'b0,
                32'h0, 32'h0)); pace();
    send(mk_req(srwf_pkg::CMD_ADD_WINDOW, pin_base[1], 3'd1, 32'h0, 2'd0, 1'b0,
                32'h0, 32'h0)); pace();
    send(mk_req(srwf_pkg::CMD_ADD_WINDOW, pin_base[2], 3'd2, 32'h0, 2'd0, 1'b0,
                32'h0, 32'h0)); pace();
    send(mk_req(srwf_pkg::CMD_ADD_WINDOW, pin_base[3], 3'd3, 32'h0, 2'd0, 1'b0,
                32'h0, 32'h0)); pace();
    // Window on a bank past the table: no protect mask
    send(mk_req(srwf_pkg::CMD_ADD_WINDOW, pin_base[4], 3'd7, 32'h0, 2'd0, 1'b0,
                32'h0, 32'h0)); pace();
    send(mk_req(srwf_pkg::CMD_ADD_WINDOW, pin_base[5], 3'd4, 32'h0, 2'd0, 1'b0,
                32'h0, 32'h0)); pace();
    send(mk_req(srwf_pkg::CMD_ADD_WINDOW, pin_base[6], 3'd6, 32'h0, 2'd0, 1'b0,
                32'h0, 32'h0)); pace();
    // Table full
    send(mk_req(srwf_pkg::CMD_ADD_WINDOW, 32'h5000_0000, 3'd5, 32'h0, 2'd0, 1'b0,
                32'h0, 32'h0));
    pace();

    // Set masks; bank 5 stays zero, bank 7 is ignored
    send(mk_req(srwf_pkg::CMD_SET_MASK, 32'h0, 3'd0, 32'hFFFF_FFFF, 2'd0, 1'b0,
                32'h0, 32'h0)); pace();
    send(mk_req(srwf_pkg::CMD_SET_MASK, 32'h0, 3'd1, 32'h0000_00FF, 2'd0, 1'b0,
                32'h0, 32'h0)); pace();
    send(mk_req(srwf_pkg::CMD_SET_MASK, 32'h0, 3'd2, 32'hF0F0_F0F0, 2'd0, 1'b0,
                32'h0, 32'h0)); pace();
    send(mk_req(srwf_pkg::CMD_SET_MASK, 32'h0, 3'd3, 32'h8000_0001, 2'd0, 1'b0,
                32'h0, 32'h0)); pace();
    send(mk_req(srwf_pkg::CMD_SET_MASK, 32'h0, 3'd7, 32'hDEAD_BEEF, 2'd0, 1'b0,
                32'h0, 32'h0)); pace();
    send(mk_req(srwf_pkg::CMD_SET_MASK, 32'h0, 3'd4, $urandom, 2'd0, 1'b0,
                32'h0, 32'h0)); pace();
    send(mk_req(srwf_pkg::CMD_SET_MASK, 32'h0, 3'd6, 32'h0000_FFFF, 2'd0, 1'b0,
                32'h0, 32'h0)); pace();

    // Pin-register accesses
    send(mk_req(srwf_pkg::CMD_PIN_ACCESS, 32'h4000_1030, 3'd0, 32'h0,
                srwf_pkg::WORD_SIZE_CODE, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000)); pace();
    send(mk_req(srwf_pkg::CMD_PIN_ACCESS, 32'h4000_103C, 3'd0, 32'h0,
                srwf_pkg::WORD_SIZE_CODE, 1'b0, 32'h0, 32'h1234_5678)); pace();
    send(mk_req(srwf_pkg::CMD_PIN_ACCESS, 32'h0000_0004, 3'd0, 32'h0, 2'd0, 1'b1,
                32'hFFFF_FFFF, 32'h0)); pace();
    send(mk_req(srwf_pkg::CMD_PIN_ACCESS, 32'hFFFF_FFFF, 3'd0, 32'h0,
                srwf_pkg::WORD_SIZE_CODE, 1'b1, 32'hA5A5_A5A5, 32'hA5A5_A5A5)); pace();
    send(mk_req(srwf_pkg::CMD_PIN_ACCESS, 32'h3FFF_FFFC, 3'd0, 32'h0,
                srwf_pkg::WORD_SIZE_CODE, 1'b1, 32'hFFFF_FFFF, 32'h0)); pace();
    send(mk_req(srwf_pkg::CMD_PIN_ACCESS, 32'h8000_0010, 3'd0, 32'h0,
                srwf_pkg::WORD_SIZE_CODE, 1'b1, 32'h0F0F_0F0F, 32'hF0F0_F0F0)); pace();

    // Pin-mux accesses: masked, zero mask, bank past table, outside window
    send(mk_req(srwf_pkg::CMD_MUX_ACCESS, mux_base, 3'd0, 32'h0,
                srwf_pkg::WORD_SIZE_CODE, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA)); pace();
    send(mk_req(srwf_pkg::CMD_MUX_ACCESS, mux_base + 5 * srwf_pkg::MUX_BANK_STRIDE, 3'd0,
                32'h0, srwf_pkg::WORD_SIZE_CODE, 1'b0, 32'h0, 32'hCAFE_0001)); pace();
    send(mk_req(srwf_pkg::CMD_MUX_ACCESS, mux_base + 7 * srwf_pkg::MUX_BANK_STRIDE, 3'd0,
                32'h0, srwf_pkg::WORD_SIZE_CODE, 1'b1, 32'hFFFF_FFFF, 32'h0)); pace();
    send(mk_req(srwf_pkg::CMD_MUX_ACCESS, mux_base + srwf_pkg::MUX_WINDOW_BYTES_DEF, 3'd0,
                32'h0, srwf_pkg::WORD_SIZE_CODE, 1'b0, 32'h0, 32'h1)); pace();
    send(mk_req(srwf_pkg::CMD_MUX_ACCESS, mux_base - 4, 3'd0, 32'h0, 2'd3, 1'b1,
                32'h1, 32'h0)); pace();

    // Random phases over several pin-mux bases
    foreach (phase_base[p]) begin
      drain_and_set_base(phase_base[p]);
      repeat (ITEMS_PER_PHASE) begin
        send(rand_req());
        pace();
      end
    end

    // Wait out the pipeline
    if (start) start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/srwf_pkg.sv
rtl/core/secure_register_write_filter.sv
test/srwf_checker.sv
test/testbench.sv
